// ----- hw/rtl/afdl_pkg.sv -----
`timescale 1ns / 1ps
package afdl_pkg;
	localparam int RATE_MAX = 240;
	localparam int ADAPT_EVERY = 60;
	localparam int WINDOW_MS = 1000;

	localparam logic [2:0] KIND_ARRIVE = 3'd0;
	localparam logic [2:0] KIND_PROC = 3'd1;
	localparam logic [2:0] KIND_DROP = 3'd2;
	localparam logic [2:0] KIND_FULL = 3'd3;
	localparam logic [2:0] KIND_LEVEL = 3'd4;

	localparam logic [2:0] REG_QLIMIT = 3'd0;
	localparam logic [2:0] REG_AEN = 3'd1;
	localparam logic [2:0] REG_CEIL = 3'd2;
	localparam logic [2:0] REG_FLOOR = 3'd3;
	localparam logic [2:0] REG_REDUCE = 3'd4;
	localparam logic [2:0] REG_RAISE = 3'd5;
	localparam logic [2:0] REG_AINT = 3'd6;

	typedef struct packed {
		logic load;
		logic div_start;
		logic div_sel_fps;
		logic commit;
		logic out_load;
	} afdl_cmd_t;

	typedef struct packed {
		logic need_fps;
		logic need_adapt;
		logic div_busy;
	} afdl_sts_t;
endpackage

// ----- hw/rtl/afdl_div.sv -----
`timescale 1ns / 1ps
module afdl_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [47:0] num,
	input  logic [32:0] den,
	output logic        busy,
	output logic [47:0] quo
);
	logic [5:0]  cnt_q;
	logic [47:0] q_q;
	logic [33:0] r_q;
	logic [33:0] rs;
	logic [33:0] rd;

	assign rs = {r_q[32:0], q_q[47]};
	assign rd = rs - {1'b0, den};
	assign busy = (cnt_q != 6'd0);
	assign quo = q_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 6'd0;
		end else if (start) begin
			cnt_q <= 6'd48;
		end else if (busy) begin
			cnt_q <= cnt_q - 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= num;
			r_q <= '0;
		end else if (busy) begin
			if (!rd[33]) begin
				r_q <= rd;
				q_q <= {q_q[46:0], 1'b1};
			end else begin
				r_q <= rs;
				q_q <= {q_q[46:0], 1'b0};
			end
		end
	end
endmodule

// ----- hw/rtl/afdl_ctrl.sv -----
`timescale 1ns / 1ps
module afdl_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  afdl_pkg::afdl_sts_t sts,
	output afdl_pkg::afdl_cmd_t cmd
);
	import afdl_pkg::*;
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_FPS = 3'd1;
	localparam logic [2:0] ST_FPSW = 3'd2;
	localparam logic [2:0] ST_ADP = 3'd3;
	localparam logic [2:0] ST_ADPW = 3'd4;
	localparam logic [2:0] ST_DONE = 3'd5;

	logic [2:0] st_q;
	logic [2:0] st_d;
	logic       ov_q;

	assign in_ready = (st_q == ST_IDLE);
	assign out_valid = ov_q;

	always_comb begin
		st_d = st_q;
		cmd = '0;
		case (st_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					st_d = ST_FPS;
				end
			end
			ST_FPS: begin
				if (sts.need_fps) begin
					cmd.div_start = 1'b1;
					cmd.div_sel_fps = 1'b1;
					st_d = ST_FPSW;
				end else begin
					st_d = ST_ADP;
				end
			end
			ST_FPSW: begin
				cmd.div_sel_fps = 1'b1;
				if (!sts.div_busy) st_d = ST_ADP;
			end
			ST_ADP: begin
				if (sts.need_adapt) begin
					cmd.div_start = 1'b1;
					st_d = ST_ADPW;
				end else begin
					st_d = ST_DONE;
				end
			end
			ST_ADPW: begin
				if (!sts.div_busy) st_d = ST_DONE;
			end
			ST_DONE: begin
				if (!ov_q || out_ready) begin
					cmd.commit = 1'b1;
					cmd.out_load = 1'b1;
					st_d = ST_IDLE;
				end
			end
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			ov_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (cmd.out_load) ov_q <= 1'b1;
			else if (out_ready) ov_q <= 1'b0;
		end
	end
endmodule

// ----- hw/rtl/afdl_dp.sv -----
`timescale 1ns / 1ps
module afdl_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  afdl_pkg::afdl_cmd_t cmd,
	output afdl_pkg::afdl_sts_t sts,
	input  logic [2:0]          kind,
	input  logic [31:0]         now_ms,
	input  logic [15:0]         queue_level_in,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_idx,
	input  logic [15:0]         cfg_data,
	output logic [31:0]         cfg_rdata,
	input  logic [2:0]          cfg_ridx,
	output logic                drop,
	output logic [15:0]         target_rate,
	output logic [15:0]         measured_rate,
	output logic                backpressure,
	output logic [9:0]          frame_gap_ms,
	output logic [31:0]         processed_count,
	output logic [31:0]         dropped_count,
	output logic [31:0]         full_events
);
	import afdl_pkg::*;

	logic [15:0] qlim_q;
	logic        aen_q;
	logic [7:0]  ceil_q, floor_q, red_q;
	logic [8:0]  rai_q;
	logic [15:0] aint_q;

	logic [31:0] last_admit_q, win_start_q, last_adapt_q;
	logic [9:0]  intv_q;
	logic [15:0] qlvl_q, tgt_q, mfps_q, winf_q;
	logic        bp_q;
	logic [31:0] proc_q, drp_q, full_q;
	logic [5:0]  acnt_q;

	logic [2:0]  k_q;
	logic [31:0] now_q;
	logic [15:0] lvl_q;

	logic [31:0] elapsed;
	logic [15:0] winf_inc;
	logic [5:0]  acnt_inc;
	logic        adapt_req;
	logic        adapt_ok;
	logic        reduce;
	logic [24:0] prod;
	logic [24:0] cand;
	logic [15:0] cand16;
	logic [7:0]  fl, lim;
	logic        raise_ok;
	logic [15:0] new_tgt;
	logic        tgt_upd;
	logic [47:0] dnum;
	logic [32:0] dden;
	logic [47:0] dquo;
	logic        dbusy;
	logic [15:0] fps_res;
	logic [9:0]  int_res;
	logic [35:0] thr_prod;
	logic [15:0] thr;
	logic        drop_c;

	assign elapsed = now_q - win_start_q;
	assign winf_inc = (winf_q != 16'hFFFF) ? winf_q + 16'd1 : winf_q;
	assign acnt_inc = acnt_q + 6'd1;
	assign adapt_req = (k_q == KIND_FULL) ||
		((k_q == KIND_PROC) && (acnt_inc >= 6'(ADAPT_EVERY)));
	assign adapt_ok = adapt_req && aen_q && ((now_q - last_adapt_q) >= {16'd0, aint_q});
	assign reduce = bp_q || (k_q == KIND_FULL) || (full_q != 32'd0);
	assign fl = (floor_q == 8'd0) ? 8'd1 : floor_q;
	assign lim = (ceil_q < 8'(RATE_MAX)) ? ceil_q : 8'(RATE_MAX);
	assign prod = reduce ? 25'(tgt_q * red_q) : 25'(tgt_q * rai_q);

	always_comb begin
		cand = {8'd0, prod[24:8]};
		if (reduce) begin
			if (cand < {9'd0, fl, 8'd0}) cand = {9'd0, fl, 8'd0};
		end else begin
			if (cand > {9'd0, lim, 8'd0}) cand = {9'd0, lim, 8'd0};
		end
	end
	assign cand16 = cand[15:0];
	assign raise_ok = cand > {9'd0, tgt_q};
	assign tgt_upd = adapt_ok && (reduce || raise_ok);
	assign new_tgt = tgt_upd ? cand16 : tgt_q;

	assign sts.need_fps = (k_q == KIND_PROC) && (elapsed >= 32'(WINDOW_MS));
	assign sts.need_adapt = tgt_upd && (cand16 >= 16'd256);
	assign sts.div_busy = dbusy;

	always_comb begin
		if (cmd.div_sel_fps) begin
			dnum = {16'd0, 32'(winf_inc * 11'd2000)} + {16'd0, elapsed};
			dden = {elapsed, 1'b0};
		end else begin
			dnum = 48'd256000;
			dden = {17'd0, cand16};
		end
	end

	afdl_div u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start),
		.num(dnum), .den(dden), .busy(dbusy), .quo(dquo)
	);

	always_ff @(posedge clk) begin
		if (cmd.div_start && cmd.div_sel_fps) fps_res <= 16'hFFFF;
		else if (cmd.div_sel_fps && !dbusy)
			fps_res <= (dquo > 48'hFFFF) ? 16'hFFFF : dquo[15:0];
	end
	assign int_res = (dquo > 48'd1000) ? 10'd1000 : dquo[9:0];

	// floor(4*limit/5) by reciprocal multiply, exact for 4*limit below 2^18
	assign thr_prod = {qlim_q, 2'b00} * 18'd209716;
	assign thr = thr_prod[35:20];
	assign drop_c = (k_q == KIND_ARRIVE) &&
		((qlvl_q >= thr) || ((now_q - last_admit_q) < {22'd0, intv_q}));

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			k_q <= kind;
			now_q <= now_ms;
			lvl_q <= queue_level_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qlim_q <= 16'd20; aen_q <= 1'b0; ceil_q <= 8'd30; floor_q <= 8'd1;
			red_q <= 8'd205; rai_q <= 9'd282; aint_q <= 16'd1000;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_QLIMIT: qlim_q <= cfg_data;
				REG_AEN:    aen_q <= cfg_data[0];
				REG_CEIL:   ceil_q <= cfg_data[7:0];
				REG_FLOOR:  floor_q <= cfg_data[7:0];
				REG_REDUCE: red_q <= cfg_data[7:0];
				REG_RAISE:  rai_q <= cfg_data[8:0];
				REG_AINT:   aint_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_ridx)
			REG_QLIMIT: cfg_rdata = {16'd0, qlim_q};
			REG_AEN:    cfg_rdata = {31'd0, aen_q};
			REG_CEIL:   cfg_rdata = {24'd0, ceil_q};
			REG_FLOOR:  cfg_rdata = {24'd0, floor_q};
			REG_REDUCE: cfg_rdata = {24'd0, red_q};
			REG_RAISE:  cfg_rdata = {23'd0, rai_q};
			REG_AINT:   cfg_rdata = {16'd0, aint_q};
			default:    cfg_rdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_admit_q <= '0; intv_q <= 10'd33; qlvl_q <= '0; tgt_q <= 16'd7680;
			mfps_q <= '0; bp_q <= 1'b0; proc_q <= '0; drp_q <= '0; full_q <= '0;
			winf_q <= '0; win_start_q <= '0; acnt_q <= '0; last_adapt_q <= '0;
		end else if (cmd.commit) begin
			case (k_q)
				KIND_ARRIVE: if (!drop_c) last_admit_q <= now_q;
				KIND_PROC: begin
					proc_q <= proc_q + 32'd1;
					if (sts.need_fps) begin
						mfps_q <= fps_res;
						winf_q <= '0;
						win_start_q <= now_q;
					end else begin
						winf_q <= winf_inc;
					end
					acnt_q <= (acnt_inc >= 6'(ADAPT_EVERY)) ? 6'd0 : acnt_inc;
				end
				KIND_DROP: drp_q <= drp_q + 32'd1;
				KIND_FULL: if (full_q != 32'hFFFFFFFF) full_q <= full_q + 32'd1;
				KIND_LEVEL: qlvl_q <= lvl_q;
				default: ;
			endcase
			if (k_q == KIND_FULL) bp_q <= 1'b1;
			if (adapt_ok) begin
				last_adapt_q <= now_q;
				if (reduce) bp_q <= 1'b0;
			end
			if (tgt_upd) begin
				tgt_q <= new_tgt;
				intv_q <= sts.need_adapt ? int_res : 10'd1000;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			drop <= drop_c;
			target_rate <= new_tgt;
			measured_rate <= sts.need_fps ? fps_res : mfps_q;
			backpressure <= adapt_ok && reduce ? 1'b0 : (bp_q || (k_q == KIND_FULL));
			frame_gap_ms <= tgt_upd ? (sts.need_adapt ? int_res : 10'd1000) : intv_q;
			processed_count <= (k_q == KIND_PROC) ? proc_q + 32'd1 : proc_q;
			dropped_count <= (k_q == KIND_DROP) ? drp_q + 32'd1 : drp_q;
			full_events <= ((k_q == KIND_FULL) && (full_q != 32'hFFFFFFFF)) ?
				full_q + 32'd1 : full_q;
		end
	end
endmodule

// ----- hw/rtl/adaptive_frame_drop_limiter_top.sv -----
`timescale 1ns / 1ps
// Frame admission limiter for one video stream. Each request passes through the states FPS,
// ADP and DONE before the next acceptance, with a wait state after FPS or ADP for each run
// of the shared restoring divider: a processed event that closes a one-second window runs it
// once, and a step that changes the target to at least 256 runs it once more. The result is
// loaded into the output register in state DONE. One request is in flight at a time; the
// result sits in an output register until taken, and a finished request waits in DONE
// while the previous result is still held.
module adaptive_frame_drop_limiter_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  kind,
	input  logic [31:0] now_ms,
	input  logic [15:0] queue_level_in,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        drop,
	output logic [15:0] target_rate,
	output logic [15:0] measured_rate,
	output logic        backpressure,
	output logic [9:0]  frame_gap_ms,
	output logic [31:0] processed_count,
	output logic [31:0] dropped_count,
	output logic [31:0] full_events,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import afdl_pkg::*;
	afdl_cmd_t cmd;
	afdl_sts_t sts;

	assign pready = 1'b1;

	afdl_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready), .sts(sts), .cmd(cmd)
	);

	afdl_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.kind(kind), .now_ms(now_ms), .queue_level_in(queue_level_in),
		.cfg_we(psel && penable && pwrite && pready),
		.cfg_idx(paddr[4:2]), .cfg_data(pwdata[15:0]),
		.cfg_rdata(prdata), .cfg_ridx(paddr[4:2]),
		.drop(drop), .target_rate(target_rate), .measured_rate(measured_rate),
		.backpressure(backpressure), .frame_gap_ms(frame_gap_ms),
		.processed_count(processed_count), .dropped_count(dropped_count),
		.full_events(full_events)
	);
endmodule

// ----- hw/rtl/afdl_chk.sv -----
`timescale 1ns / 1ps
module afdl_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic        drop,
	input logic [9:0]  frame_gap_ms,
	input logic [31:0] full_events
);
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready) else $error("back to back request");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(drop))) else $error("result lost");
	a_int: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (frame_gap_ms >= 10'd4 && frame_gap_ms <= 10'd1000))
		else $error("interval");
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && $past(out_valid)) |-> full_events >= $past(full_events))
		else $error("full count dropped");
endmodule

bind adaptive_frame_drop_limiter_top afdl_chk u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .drop(drop),
	.frame_gap_ms(frame_gap_ms), .full_events(full_events)
);
